@@ rtl/core/sqg_pkg.sv @@
package sqg_pkg;

    localparam int DEF_MAX_QUBITS = 12;
    localparam int DEF_AMP_WIDTH  = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int GEO_W      = 4;

    localparam int COEF_W    = 16;
    localparam int COEF_FRAC = 15;

    localparam logic [GEO_W-1:0]      QUBITS_RST = 4'd12;
    localparam logic [GEO_W-1:0]      TARGET_RST = 4'd0;
    localparam logic [CFG_DATA_W-1:0] COEF_ONE   = 32'h7FFF_0000;
    localparam logic [CFG_DATA_W-1:0] COEF_ZERO  = 32'h0000_0000;

    localparam int GATE_U00 = 0;
    localparam int GATE_U01 = 1;
    localparam int GATE_U10 = 2;
    localparam int GATE_U11 = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_QUBITS = 3'd0,
        CFG_TARGET = 3'd1,
        CFG_U00    = 3'd2,
        CFG_U01    = 3'd3,
        CFG_U10    = 3'd4,
        CFG_U11    = 3'd5
    } t_cfg_idx;

    typedef logic [3:0][CFG_DATA_W-1:0] t_gate;

    typedef struct packed {
        logic pair;
        logic last;
    } t_item_ctl;

endpackage

@@ rtl/core/sqg_ram.sv @@
module sqg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/sqg_index.sv @@
module sqg_index import sqg_pkg::*; #(
    parameter int MAX_QUBITS = DEF_MAX_QUBITS,
    parameter int ADDR_W     = (MAX_QUBITS > 1) ? MAX_QUBITS - 1 : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [GEO_W-1:0]      i_cfg_geo,
    input  logic                  i_advance,
    output logic [MAX_QUBITS-1:0] o_idx,
    output logic [MAX_QUBITS-1:0] o_i0,
    output logic [MAX_QUBITS-1:0] o_size_mask,
    output logic [ADDR_W-1:0]     o_addr,
    output t_item_ctl             o_ctl
);

    localparam int IW = MAX_QUBITS;
    localparam int NB = $clog2(MAX_QUBITS + 1);
    localparam int CW = (NB > GEO_W) ? NB : GEO_W;

    logic [GEO_W-1:0] r_qubits;
    logic [GEO_W-1:0] r_target;
    logic [IW-1:0]    r_next_index;
    logic [IW-1:0]    n_next_index;

    logic [CW-1:0] q_c;
    logic [CW-1:0] k_c;
    logic [CW-1:0] n_c;
    logic [CW-1:0] k_lim;
    logic [CW-1:0] t_c;
    logic [IW:0]   size_wide;
    logic [IW-1:0] size_mask;
    logic [IW-1:0] tgt_mask;
    logic [IW-1:0] low_mask;
    logic [IW-1:0] idx;
    logic [IW-1:0] addr_full;

    always_comb begin
        q_c = CW'(r_qubits);
        k_c = CW'(r_target);
        if (q_c == '0) begin
            n_c = CW'(1);
        end else if (q_c > CW'(MAX_QUBITS)) begin
            n_c = CW'(MAX_QUBITS);
        end else begin
            n_c = q_c;
        end
        k_lim     = (k_c > n_c - CW'(1)) ? n_c - CW'(1) : k_c;
        t_c       = n_c - CW'(1) - k_lim;
        size_wide = ((IW+1)'(1) << n_c) - (IW+1)'(1);
        size_mask = size_wide[IW-1:0];
        tgt_mask  = IW'(1) << t_c;
        low_mask  = tgt_mask - IW'(1);
        idx       = r_next_index & size_mask;
        addr_full = ((idx >> 1) & ~low_mask) | (idx & low_mask);
        n_next_index = (idx + IW'(1)) & size_mask;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qubits     <= QUBITS_RST;
            r_target     <= TARGET_RST;
            r_next_index <= '0;
        end else if (i_cfg_wr_en && t_cfg_idx'(i_cfg_addr) == CFG_QUBITS) begin
            r_qubits     <= i_cfg_geo;
            r_next_index <= '0;
        end else if (i_cfg_wr_en && t_cfg_idx'(i_cfg_addr) == CFG_TARGET) begin
            r_target     <= i_cfg_geo;
            r_next_index <= '0;
        end else if (i_advance) begin
            r_next_index <= n_next_index;
        end
    end

    assign o_idx       = idx;
    assign o_i0        = idx & ~tgt_mask;
    assign o_size_mask = size_mask;
    assign o_addr      = addr_full[ADDR_W-1:0];
    assign o_ctl.pair  = |(idx & tgt_mask);
    assign o_ctl.last  = (idx == size_mask);

endmodule

@@ rtl/core/sqg_cmac.sv @@
module sqg_cmac import sqg_pkg::*; #(
    parameter int MAX_QUBITS = DEF_MAX_QUBITS,
    parameter int AMP_WIDTH  = DEF_AMP_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_gate                        i_gate,
    input  logic                         i_load,
    input  logic [MAX_QUBITS-1:0]        i_idx,
    input  logic [MAX_QUBITS-1:0]        i_i0,
    input  logic                         i_last,
    input  logic signed [AMP_WIDTH-1:0]  i_a1_re,
    input  logic signed [AMP_WIDTH-1:0]  i_a1_im,
    input  logic [2*AMP_WIDTH-1:0]       i_a0,
    output logic                         o_load_ready,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [MAX_QUBITS-1:0]        o_index,
    output logic signed [AMP_WIDTH-1:0]  o_re,
    output logic signed [AMP_WIDTH-1:0]  o_im,
    output logic                         o_last
);

    localparam int AW = AMP_WIDTH;
    localparam int IW = MAX_QUBITS;
    localparam int PW = COEF_W + AW;
    localparam int RW = AW + 1;
    localparam int SW = AW + 3;
    localparam int NL = 8;

    localparam logic [AW-1:0] SAT_MAX = {1'b0, {(AW-1){1'b1}}};
    localparam logic [AW-1:0] SAT_MIN = {1'b1, {(AW-1){1'b0}}};

    logic                 r1_valid;
    logic                 r1_row;
    logic [IW-1:0]        r1_idx;
    logic [IW-1:0]        r1_i0;
    logic                 r1_last;
    logic signed [AW-1:0] r1_a1_re;
    logic signed [AW-1:0] r1_a1_im;

    logic                 r2_valid;
    logic [IW-1:0]        r2_idx;
    logic                 r2_last;
    logic signed [RW-1:0] r2_p [NL];

    logic                 r3_valid;
    logic [IW-1:0]        r3_idx;
    logic                 r3_last;
    logic [AW-1:0]        r3_re;
    logic [AW-1:0]        r3_im;

    logic s1_fire;
    logic s2_ready;
    logic s3_ready;

    logic [CFG_DATA_W-1:0]    coef_a;
    logic [CFG_DATA_W-1:0]    coef_b;
    logic signed [COEF_W-1:0] car, cai, cbr, cbi;
    logic signed [AW-1:0]     a0r, a0i;
    logic signed [COEF_W-1:0] mul_c [NL];
    logic signed [AW-1:0]     mul_a [NL];
    logic signed [PW-1:0]     prod  [NL];
    logic signed [PW-1:0]     prod_r [NL];
    logic signed [PW-1:0]     prod_s [NL];
    logic signed [RW-1:0]     n_p   [NL];

    logic signed [SW-1:0] sum_re;
    logic signed [SW-1:0] sum_im;
    logic [AW-1:0]        n_re;
    logic [AW-1:0]        n_im;

    assign s3_ready     = !r3_valid || i_ready;
    assign s2_ready     = !r2_valid || s3_ready;
    assign s1_fire      = r1_valid && s2_ready;
    assign o_load_ready = !r1_valid || (r1_row && s2_ready);

    always_comb begin
        coef_a = r1_row ? i_gate[GATE_U10] : i_gate[GATE_U00];
        coef_b = r1_row ? i_gate[GATE_U11] : i_gate[GATE_U01];
        car = coef_a[31:16];
        cai = coef_a[15:0];
        cbr = coef_b[31:16];
        cbi = coef_b[15:0];
        a0r = i_a0[AW-1:0];
        a0i = i_a0[2*AW-1:AW];
        mul_c[0] = car; mul_a[0] = a0r;
        mul_c[1] = cai; mul_a[1] = a0i;
        mul_c[2] = cbr; mul_a[2] = r1_a1_re;
        mul_c[3] = cbi; mul_a[3] = r1_a1_im;
        mul_c[4] = car; mul_a[4] = a0i;
        mul_c[5] = cai; mul_a[5] = a0r;
        mul_c[6] = cbr; mul_a[6] = r1_a1_im;
        mul_c[7] = cbi; mul_a[7] = r1_a1_re;
        for (int j = 0; j < NL; j++) begin
            prod[j]   = mul_c[j] * mul_a[j];
            prod_r[j] = prod[j] + PW'(1 << (COEF_FRAC - 1));
            prod_s[j] = prod_r[j] >>> COEF_FRAC;
            n_p[j]    = prod_s[j][RW-1:0];
        end
    end

    always_comb begin
        sum_re = SW'(r2_p[0]) - SW'(r2_p[1]) + SW'(r2_p[2]) - SW'(r2_p[3]);
        sum_im = SW'(r2_p[4]) + SW'(r2_p[5]) + SW'(r2_p[6]) + SW'(r2_p[7]);
        if (sum_re[SW-1:AW-1] == {(SW-AW+1){sum_re[SW-1]}}) begin
            n_re = sum_re[AW-1:0];
        end else begin
            n_re = sum_re[SW-1] ? SAT_MIN : SAT_MAX;
        end
        if (sum_im[SW-1:AW-1] == {(SW-AW+1){sum_im[SW-1]}}) begin
            n_im = sum_im[AW-1:0];
        end else begin
            n_im = sum_im[SW-1] ? SAT_MIN : SAT_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r1_row   <= 1'b0;
        end else if (i_load) begin
            r1_valid <= 1'b1;
            r1_row   <= 1'b0;
        end else if (s1_fire) begin
            r1_valid <= !r1_row;
            r1_row   <= !r1_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r1_idx   <= i_idx;
            r1_i0    <= i_i0;
            r1_last  <= i_last;
            r1_a1_re <= i_a1_re;
            r1_a1_im <= i_a1_im;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (s2_ready) begin
            r2_valid <= s1_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r2_idx  <= r1_row ? r1_idx : r1_i0;
            r2_last <= r1_row && r1_last;
            for (int j = 0; j < NL; j++) begin
                r2_p[j] <= n_p[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (s3_ready) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_ready && r2_valid) begin
            r3_idx  <= r2_idx;
            r3_last <= r2_last;
            r3_re   <= n_re;
            r3_im   <= n_im;
        end
    end

    assign o_valid = r3_valid;
    assign o_index = r3_idx;
    assign o_re    = r3_re;
    assign o_im    = r3_im;
    assign o_last  = r3_last;

endmodule

@@ rtl/core/single_qubit_gate_state_vector.sv @@
// Channel   Dir  Handshake              Payload
// s-side    in   i_s_tvalid/o_s_tready  i_s_tdata: amp_real, amp_imag
// m-side    out  o_m_tvalid/i_m_tready  o_m_tdata: out_index, out_real, out_imag;
//                                       o_m_tlast: vector_done
// cfg       in   i_cfg_wr_en            i_cfg_addr, i_cfg_wr_data
//
// An item whose target bit is clear is written to the pair buffer. An item whose
// target bit is set reads its partner and holds the MAC stage for two results,
// one per cycle while the output does not stall; the next such item is taken as
// the second result leaves. Results pass through the operand, product and output
// registers; the output register lets the next item in while a result waits.
// Reset clears control and geometry; the pair buffer is not cleared.
module single_qubit_gate_state_vector import sqg_pkg::*; #(
    parameter int MAX_QUBITS = DEF_MAX_QUBITS,
    parameter int AMP_WIDTH  = DEF_AMP_WIDTH,
    parameter int IN_W       = ((2 * AMP_WIDTH + 7) / 8) * 8,
    parameter int OUT_W      = ((MAX_QUBITS + 2 * AMP_WIDTH + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_W-1:0]       i_s_tdata,  // amp_real, amp_imag
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_W-1:0]      o_m_tdata,  // out_index, out_real, out_imag
    output logic                  o_m_tlast,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wr_data
);

    localparam int AW     = AMP_WIDTH;
    localparam int IW     = MAX_QUBITS;
    localparam int ADDR_W = (MAX_QUBITS > 1) ? MAX_QUBITS - 1 : 1;
    localparam int DEPTH  = 1 << ADDR_W;

    t_gate r_gate;

    logic [IW-1:0]     idx;
    logic [IW-1:0]     i0;
    logic [IW-1:0]     size_mask;
    logic [ADDR_W-1:0] addr;
    t_item_ctl         ctl;

    logic                 accept;
    logic                 job_ready;
    logic                 ram_we;
    logic                 ram_re;
    logic [2*AW-1:0]      a0;
    logic signed [AW-1:0] a1_re;
    logic signed [AW-1:0] a1_im;
    logic [IW-1:0]        out_index;
    logic [AW-1:0]        out_re;
    logic [AW-1:0]        out_im;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate[GATE_U00] <= COEF_ONE;
            r_gate[GATE_U01] <= COEF_ZERO;
            r_gate[GATE_U10] <= COEF_ZERO;
            r_gate[GATE_U11] <= COEF_ONE;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_U00: r_gate[GATE_U00] <= i_cfg_wr_data;
                CFG_U01: r_gate[GATE_U01] <= i_cfg_wr_data;
                CFG_U10: r_gate[GATE_U10] <= i_cfg_wr_data;
                CFG_U11: r_gate[GATE_U11] <= i_cfg_wr_data;
                default: ;
            endcase
        end
    end

    assign a1_re      = i_s_tdata[AW-1:0];
    assign a1_im      = i_s_tdata[2*AW-1:AW];
    assign o_s_tready = !ctl.pair || job_ready;
    assign accept     = i_s_tvalid && o_s_tready;
    assign ram_we     = accept && !ctl.pair;
    assign ram_re     = accept && ctl.pair;

    sqg_index #(
        .MAX_QUBITS (MAX_QUBITS),
        .ADDR_W     (ADDR_W)
    ) u_index (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_geo   (i_cfg_wr_data[GEO_W-1:0]),
        .i_advance   (accept),
        .o_idx       (idx),
        .o_i0        (i0),
        .o_size_mask (size_mask),
        .o_addr      (addr),
        .o_ctl       (ctl)
    );

    sqg_ram #(
        .WIDTH (2 * AW),
        .DEPTH (DEPTH)
    ) u_pair_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (addr),
        .i_wdata ({a1_im, a1_re}),
        .i_re    (ram_re),
        .i_raddr (addr),
        .o_rdata (a0)
    );

    sqg_cmac #(
        .MAX_QUBITS (MAX_QUBITS),
        .AMP_WIDTH  (AMP_WIDTH)
    ) u_cmac (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_gate       (r_gate),
        .i_load       (ram_re),
        .i_idx        (idx),
        .i_i0         (i0),
        .i_last       (ctl.last),
        .i_a1_re      (a1_re),
        .i_a1_im      (a1_im),
        .i_a0         (a0),
        .o_load_ready (job_ready),
        .o_valid      (o_m_tvalid),
        .i_ready      (i_m_tready),
        .o_index      (out_index),
        .o_re         (out_re),
        .o_im         (out_im),
        .o_last       (o_m_tlast)
    );

    assign o_m_tdata = OUT_W'({out_im, out_re, out_index});

    a_ram_port_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("pair buffer written and read in one cycle");

    a_stall_only_on_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (ctl.pair && !job_ready))
        else $error("input stalled without a busy MAC stage");

    a_last_is_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> (out_index == size_mask))
        else $error("vector end flagged on a non-final index");

    a_pair_idx_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && ctl.last && !i_cfg_wr_en) |=> (idx == '0))
        else $error("index did not wrap after the final item");

endmodule
